FILE: src/pee_pkg.sv
`timescale 1ns / 1ps
// Package for the prefix expression evaluator: opcodes, status codes,
// controller/datapath command and status structs, and the token decoder.
// No dependencies.
package pee_pkg;

    // Character codes of the expression alphabet.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_MAX  = 8'd9;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_PCT   = 8'h25;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_OVER    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_ZNEGPOW = 3'd5;

    // The iterative unit runs one step per bit of a 32-bit operand.
    localparam int          ITER_STEPS = 32;
    localparam logic [4:0]  ITER_LAST  = 5'(ITER_STEPS - 1);

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_POW,
        OP_OTHER
    } pee_op_t;

    typedef enum logic [1:0] {
        PUSH_DIGIT,
        PUSH_ALU,
        PUSH_ITER
    } pee_push_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_token;
        logic       rd_top;
        logic       rd_second;
        logic       latch_a;
        logic       pop_two;
        logic       push;
        pee_push_t  push_src;
        logic       start_iter;
        logic       set_err;
        logic [2:0] err_code;
        logic       out_load;
    } pee_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        pee_op_t op;
        logic    final_tok;
        logic    full;
        logic    lt2;
        logic    a_zero;
        logic    b_zero;
        logic    b_neg;
        logic    iter_done;
        logic    out_busy;
    } pee_stat_t;

    // Classify one expression character.
    function automatic pee_op_t pee_decode(input logic [7:0] c);
        pee_op_t op;
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + DIGIT_MAX) begin
            op = OP_DIGIT;
        end
        else begin
            case (c)
                CHAR_PLUS:  op = OP_ADD;
                CHAR_MINUS: op = OP_SUB;
                CHAR_STAR:  op = OP_MUL;
                CHAR_SLASH: op = OP_DIV;
                CHAR_PCT:   op = OP_MOD;
                CHAR_CARET: op = OP_POW;
                default:    op = OP_OTHER;
            endcase
        end
        return op;
    endfunction

endpackage

FILE: src/pee_token_if.sv
`timescale 1ns / 1ps
// Input channel of the prefix expression evaluator: one character per transaction.
// Depends on nothing.
interface pee_token_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic       final_token;

    modport source (output valid, output token_char, output final_token, input ready);
    modport sink (input valid, input token_char, input final_token, output ready);
endinterface

FILE: src/pee_result_if.sv
`timescale 1ns / 1ps
// Output channel of the prefix expression evaluator: value and status per transaction.
// Depends on nothing.
interface pee_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

FILE: src/pee_iter.sv
`timescale 1ns / 1ps
// Iterative unit: signed divide/modulo (restoring, one bit per cycle) and power
// (square and multiply, one exponent bit per cycle). Depends on pee_pkg.
module pee_iter
    import pee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_pow,
    input  logic        is_mod,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        pow_reg, pow_next;
    logic        mod_reg, mod_next;
    logic        neg_reg, neg_next;
    // w: dividend shifting into quotient, or exponent.
    // acc: partial remainder, or power accumulator.
    // base: divisor magnitude, or running square.
    logic [31:0] w_reg, w_next;
    logic [32:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic [31:0] acc_prod;
    logic [31:0] base_prod;
    logic [31:0] a_mag;
    logic [31:0] b_mag;

    assign a_mag     = a[31] ? (32'd0 - a) : a;
    assign b_mag     = b[31] ? (32'd0 - b) : b;
    assign shifted   = {acc_reg[31:0], w_reg[31]};
    assign trial     = shifted - {1'b0, base_reg};
    assign acc_prod  = acc_reg[31:0] * base_reg;
    assign base_prod = base_reg * base_reg;

    // Next-state logic for one step of the selected operation.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        pow_next  = pow_reg;
        mod_next  = mod_reg;
        neg_next  = neg_reg;
        w_next    = w_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            pow_next  = is_pow;
            mod_next  = is_mod;
            neg_next  = is_mod ? a[31] : (a[31] ^ b[31]);
            if (is_pow) begin
                w_next    = b;
                acc_next  = 33'd1;
                base_next = a;
            end
            else begin
                w_next    = a_mag;
                acc_next  = '0;
                base_next = b_mag;
            end
        end
        else if (busy_reg) begin
            if (pow_reg) begin
                if (w_reg[0]) begin
                    acc_next = {1'b0, acc_prod};
                end
                base_next = base_prod;
                w_next    = {1'b0, w_reg[31:1]};
            end
            else if (!trial[32]) begin
                acc_next = trial;
                w_next   = {w_reg[30:0], 1'b1};
            end
            else begin
                acc_next = shifted;
                w_next   = {w_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == ITER_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        pow_reg  <= pow_next;
        mod_reg  <= mod_next;
        neg_reg  <= neg_next;
        w_reg    <= w_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
    end

    // Result select: the power accumulator as is, or the sign-corrected quotient or remainder.
    always_comb
    begin
        if (pow_reg) begin
            result = acc_reg[31:0];
        end
        else if (mod_reg) begin
            result = neg_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
        end
        else begin
            result = neg_reg ? (32'd0 - w_reg) : w_reg;
        end
    end

    assign done = done_reg;

endmodule

FILE: src/pee_datapath.sv
`timescale 1ns / 1ps
// Datapath: token register, operand stack memory, operand registers, simple ALU,
// sticky error, output register. Depends on pee_pkg and pee_iter.
module pee_datapath
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pee_cmd_t    cmd,
    output pee_stat_t   stat,
    input  logic [7:0]  token_char,
    input  logic        final_token,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_value,
    output logic [2:0]  out_status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0]    char_reg;
    logic          final_reg;
    logic [31:0]   a_reg;
    logic [31:0]   b_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    err_reg, err_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   value_reg;
    logic [2:0]    status_reg;
    logic [31:0]   rdata_reg;
    logic [31:0]   mem [STACK_DEPTH];

    pee_op_t       op;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] count_m2;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic [31:0]   digit_val;
    logic [31:0]   alu_val;
    logic [31:0]   push_data;
    logic          empty;
    logic          iter_done;
    logic [31:0]   iter_result;

    assign op        = pee_decode(char_reg);
    assign count_m1  = count_reg - CW'(1);
    assign count_m2  = count_reg - CW'(2);
    assign empty     = (count_reg == '0);
    assign digit_val = {24'd0, char_reg - CHAR_ZERO};

    // Token capture on an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load_token) begin
            char_reg  <= token_char;
            final_reg <= final_token;
        end
    end

    // Operand registers: a is the old top, b the entry under it.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_a) begin
            a_reg <= rdata_reg;
        end
        if (cmd.pop_two) begin
            b_reg <= rdata_reg;
        end
    end

    // ALU for the combinational results, the zero divisor and negative exponents.
    always_comb
    begin
        case (op)
            OP_ADD:  alu_val = a_reg + b_reg;
            OP_SUB:  alu_val = a_reg - b_reg;
            OP_MUL:  alu_val = a_reg * b_reg;
            OP_POW:
            begin
                if (a_reg == 32'd1) begin
                    alu_val = 32'd1;
                end
                else if (a_reg == 32'hFFFF_FFFF) begin
                    alu_val = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                end
                else begin
                    alu_val = 32'd0;
                end
            end
            default: alu_val = 32'd0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.push_src)
            PUSH_DIGIT: push_data = digit_val;
            PUSH_ALU:   push_data = alu_val;
            PUSH_ITER:  push_data = iter_result;
            default:    push_data = alu_val;
        endcase
    end

    // Stack memory: one write port at the count, one registered read port.
    assign rd_en = cmd.rd_top | cmd.rd_second;
    assign raddr = cmd.rd_second ? count_m2[AW-1:0] : count_m1[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push) begin
            mem[count_reg[AW-1:0]] <= push_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Stack count, sticky error and output valid.
    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.pop_two) begin
            count_next = count_m2;
        end
        else if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_err && err_reg == ST_OK) begin
            err_next = cmd.err_code;
        end
        if (cmd.out_load) begin
            count_next = '0;
            err_next   = ST_OK;
        end
        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register; the top entry was read in S_FIN, before the S_OUT state that loads it.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            value_reg <= empty ? 32'd0 : rdata_reg;
            if (err_reg != ST_OK) begin
                status_reg <= err_reg;
            end
            else if (empty) begin
                status_reg <= ST_EMPTY;
            end
            else begin
                status_reg <= ST_OK;
            end
        end
    end

    pee_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_iter),
        .is_pow (op == OP_POW),
        .is_mod (op == OP_MOD),
        .a      (a_reg),
        .b      (b_reg),
        .done   (iter_done),
        .result (iter_result)
    );

    // Status toward the controller.
    always_comb
    begin
        stat.op        = op;
        stat.final_tok = final_reg;
        stat.full      = (count_reg == CW'(STACK_DEPTH));
        stat.lt2       = (count_reg < CW'(2));
        stat.a_zero    = (a_reg == 32'd0);
        stat.b_zero    = (b_reg == 32'd0);
        stat.b_neg     = b_reg[31];
        stat.iter_done = iter_done;
        stat.out_busy  = out_valid_reg & ~out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;

endmodule

FILE: src/pee_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences decode, pops, execution, push and the result.
// Depends on pee_pkg.
module pee_ctrl
    import pee_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pee_stat_t stat,
    output pee_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_POP_A  = 3'd2;
    localparam logic [2:0] S_POP_B  = 3'd3;
    localparam logic [2:0] S_EXEC   = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.push_src   = PUSH_ALU;
        cmd.err_code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load_token = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op == OP_DIGIT) begin
                    if (stat.full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVER;
                    end
                    else begin
                        cmd.push     = 1'b1;
                        cmd.push_src = PUSH_DIGIT;
                    end
                    state_next = S_FIN;
                end
                else if (stat.lt2) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ST_UNDER;
                    state_next   = S_FIN;
                end
                else begin
                    cmd.rd_top = 1'b1;
                    state_next = S_POP_A;
                end
            end
            S_POP_A:
            begin
                cmd.latch_a   = 1'b1;
                cmd.rd_second = 1'b1;
                state_next    = S_POP_B;
            end
            S_POP_B:
            begin
                cmd.pop_two = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                case (stat.op) inside
                    OP_ADD, OP_SUB, OP_MUL:
                    begin
                        cmd.push = 1'b1;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (stat.b_zero) begin
                            cmd.push     = 1'b1;
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_DIVZERO;
                        end
                        else begin
                            cmd.start_iter = 1'b1;
                            state_next     = S_WAIT;
                        end
                    end
                    OP_POW:
                    begin
                        if (stat.b_neg) begin
                            cmd.push     = 1'b1;
                            cmd.set_err  = stat.a_zero;
                            cmd.err_code = ST_ZNEGPOW;
                        end
                        else begin
                            cmd.start_iter = 1'b1;
                            state_next     = S_WAIT;
                        end
                    end
                    default:
                    begin
                        // Unknown operator: both operands are dropped.
                    end
                endcase
            end
            S_WAIT:
            begin
                if (stat.iter_done) begin
                    cmd.push     = 1'b1;
                    cmd.push_src = PUSH_ITER;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.final_tok) begin
                    cmd.rd_top = 1'b1;
                    state_next = S_OUT;
                end
                else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free.
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/prefix_expression_evaluator_unit.sv
`timescale 1ns / 1ps
// Top level of the prefix expression evaluator: controller plus datapath.
// Depends on pee_pkg, pee_token_if, pee_result_if, pee_ctrl, pee_datapath.
//
//   Channel  Dir  Payload                         Transaction
//   token    in   token_char[7:0], final_token    one character, right to left
//   result   out  value[31:0] signed, status[2:0] one per final character
//
// A digit, or an operator with fewer than two operands, needs no pops; + - *, unknown
// characters, a zero divisor and a negative exponent take the two pops through the single
// registered read port; / % ^ otherwise also wait on the 32-step iterative divide and power
// unit. A final character adds the state that loads the top entry into the output register.
// Reset clears the stack count, the sticky error and the output valid.
// A result waiting in the output register stalls only the next final character.
module prefix_expression_evaluator_unit
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    pee_token_if.sink   token,
    pee_result_if.source result
);

    pee_cmd_t    cmd;
    pee_stat_t   stat;
    logic [31:0] value_bits;

    pee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (token.valid),
        .in_ready (token.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pee_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .token_char  (token.token_char),
        .final_token (token.final_token),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_value   (value_bits),
        .out_status  (result.status)
    );

    assign result.value = $signed(value_bits);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for prefix_expression_evaluator_unit: feeds prefix expressions
// one character per transaction and checks each result against an internal stack evaluator.
// Depends on pee_pkg, pee_token_if, pee_result_if and the evaluator RTL.
module testbench;
    import pee_pkg::*;

    localparam int STACK_DEPTH   = 32;
    localparam int TOKEN_TARGET  = 550;
    localparam int SETTLE_CYCLES = 80;

    // One expected evaluation: the top of the stack and the status code.
    typedef struct {
        logic signed [31:0] value;
        logic        [2:0]  status;
    } evaluation_t;

    // Stack evaluator and result checker.
    class expression_scoreboard;
        logic [31:0]  operand_stack[STACK_DEPTH];
        int unsigned  stack_fill;
        logic [2:0]   first_error;
        evaluation_t  pending_results[$];
        int unsigned  mismatch_count;
        int unsigned  results_checked;
        int unsigned  status_seen[8];

        function new();
            stack_fill = 0;
            first_error = ST_OK;
            mismatch_count = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        task report(input string msg);
            mismatch_count++;
            if (mismatch_count <= 20)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Only the first error since the last result is kept.
        function void keep_error(input logic [2:0] code);
            if (first_error == ST_OK)
                first_error = code;
        endfunction

        function void push_operand(input logic [31:0] v);
            if (stack_fill >= STACK_DEPTH) begin
                keep_error(ST_OVER);
            end
            else begin
                operand_stack[stack_fill] = v;
                stack_fill++;
            end
        endfunction

        function logic [31:0] abs_value(input logic [31:0] v);
            return v[31] ? -v : v;
        endfunction

        // Power by square and multiply, wrapping at 32 bits.
        function logic [31:0] raise_power(input logic [31:0] base, input logic [31:0] expo);
            logic [31:0] acc;
            logic [31:0] sq;
            logic [31:0] e;
            if (expo[31]) begin
                if (base == 32'd1)
                    return 32'd1;
                if (base == 32'hFFFF_FFFF)
                    return expo[0] ? 32'hFFFF_FFFF : 32'd1;
                if (base == 32'd0)
                    keep_error(ST_ZNEGPOW);
                return 32'd0;
            end
            acc = 32'd1;
            sq = base;
            e = expo;
            for (int i = 0; i < 32; i++) begin
                if (e[0])
                    acc = acc * sq;
                sq = sq * sq;
                e = e >> 1;
            end
            return acc;
        endfunction

        function pee_op_t classify(input logic [7:0] c);
            if (c >= CHAR_ZERO && c <= CHAR_ZERO + DIGIT_MAX)
                return OP_DIGIT;
            case (c)
                CHAR_PLUS:  return OP_ADD;
                CHAR_MINUS: return OP_SUB;
                CHAR_STAR:  return OP_MUL;
                CHAR_SLASH: return OP_DIV;
                CHAR_PCT:   return OP_MOD;
                CHAR_CARET: return OP_POW;
                default:    return OP_OTHER;
            endcase
        endfunction

        // Apply one accepted character; a final character queues the expected result.
        function void note_token(input logic [7:0] c, input logic fin);
            pee_op_t     kind;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] q;
            logic [31:0] r;
            evaluation_t ev;
            kind = classify(c);
            if (kind == OP_DIGIT) begin
                push_operand({24'd0, c - CHAR_ZERO});
            end
            else if (stack_fill < 2) begin
                keep_error(ST_UNDER);
            end
            else begin
                a = operand_stack[stack_fill - 1];
                b = operand_stack[stack_fill - 2];
                stack_fill -= 2;
                case (kind) inside
                    OP_ADD: push_operand(a + b);
                    OP_SUB: push_operand(a - b);
                    OP_MUL: push_operand(a * b);
                    OP_DIV, OP_MOD: begin
                        if (b == 32'd0) begin
                            keep_error(ST_DIVZERO);
                            push_operand(32'd0);
                        end
                        else begin
                            // Truncate toward zero; the remainder follows the sign of a.
                            q = abs_value(a) / abs_value(b);
                            r = abs_value(a) % abs_value(b);
                            if (kind == OP_DIV)
                                push_operand((a[31] ^ b[31]) ? -q : q);
                            else
                                push_operand(a[31] ? -r : r);
                        end
                    end
                    OP_POW: push_operand(raise_power(a, b));
                    default: ;
                endcase
            end
            if (fin) begin
                ev.value = (stack_fill > 0) ? operand_stack[stack_fill - 1] : 32'd0;
                if (first_error != ST_OK)
                    ev.status = first_error;
                else if (stack_fill == 0)
                    ev.status = ST_EMPTY;
                else
                    ev.status = ST_OK;
                pending_results.push_back(ev);
                stack_fill = 0;
                first_error = ST_OK;
            end
        endfunction

        task check_result(input logic signed [31:0] value, input logic [2:0] status);
            evaluation_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result value %0d status %0d with nothing expected",
                                 value, status));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (!$isunknown(status))
                status_seen[status]++;
            if (value !== want.value)
                report($sformatf("value %0d, expected %0d", value, want.value));
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;

    pee_token_if  token_ch();
    pee_result_if result_ch();

    expression_scoreboard sb = new();

    logic [7:0] expression_chars[$];
    int         burst_left;
    int         tokens_sent;
    int         expressions_sent;

    // Directed expressions in written (prefix) order.
    string directed_texts[6] = '{"/^2+*934-01", "^0-01", "%70", "+5", "x12", "9"};

    // Occasional special forms mixed into the random part.
    string special_texts[18] = '{
        "^1-01", "^-01-01", "^-01-02", "^5-01", "^0-01", "%^2+*934-01",
        "/^2+*934-01", "/-073", "%-073", "%7-03", "x12", "+5", "0", "/00",
        "^00", "^99", "-0^2+*934", "-^2+*9341"
    };

    prefix_expression_evaluator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (token_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one character and wait until the transaction is taken.
    task send_token(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                token_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        token_ch.valid       <= 1'b1;
        token_ch.token_char  <= c;
        token_ch.final_token <= fin;
        @(posedge clk);
        while (!token_ch.ready) @(posedge clk);
        sb.note_token(c, fin);
        burst_left--;
        tokens_sent++;
    endtask

    // Send the queued characters in feed order; the last one is final.
    task send_expression();
        int n;
        n = expression_chars.size();
        for (int i = 0; i < n; i++)
            send_token(expression_chars[i], i == n - 1);
        expression_chars.delete();
        expressions_sent++;
    endtask

    // Queue a prefix text right to left.
    task queue_text(input string s);
        for (int i = s.len() - 1; i >= 0; i--)
            expression_chars.push_back(s[i]);
    endtask

    function logic [7:0] pick_operator(input bit allow_stray);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 4)  return CHAR_PLUS;
        if (pick < 8)  return CHAR_MINUS;
        if (pick < 12) return CHAR_STAR;
        if (pick < 14) return CHAR_SLASH;
        if (pick < 16) return CHAR_PCT;
        if (pick < 19) return CHAR_CARET;
        return allow_stray ? 8'($urandom_range(0, 255)) : CHAR_PLUS;
    endfunction

    // Build a well-formed expression in feed order (an operator may be a stray character
    // if allow_stray is set), keeping two operands available before every operator.
    task queue_wellformed(input int nops, input bit allow_stray);
        int digits_left;
        int ops_left;
        int fill;
        bit take_digit;
        digits_left = nops + 1;
        ops_left = nops;
        fill = 0;
        while (digits_left + ops_left > 0) begin
            if (fill < 2 || ops_left == 0)
                take_digit = 1'b1;
            else if (digits_left == 0)
                take_digit = 1'b0;
            else
                take_digit = $urandom_range(0, 1);
            if (take_digit) begin
                expression_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                digits_left--;
                fill++;
            end
            else begin
                expression_chars.push_back(pick_operator(allow_stray));
                ops_left--;
                fill--;
            end
        end
    endtask

    // Result channel: check each accepted transaction, stall on a changing rhythm.
    initial
    begin
        int mode;
        int left;
        int phase;
        result_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        phase = 0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.value, result_ch.status);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(40, 300);
            end
            left--;
            phase++;
            case (mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       result_ch.ready <= (phase % 13) >= 9;
                default: result_ch.ready <= (phase % 5) != 0;
            endcase
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int kind;
        int cut;
        rst_n                <= 1'b0;
        token_ch.valid       <= 1'b0;
        token_ch.token_char  <= 8'd0;
        token_ch.final_token <= 1'b0;
        burst_left = 0;
        tokens_sent = 0;
        expressions_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases: most negative over minus one, zero to a negative power,
        // modulo by zero, too few operands, emptied stack and a lone digit.
        foreach (directed_texts[i]) begin
            queue_text(directed_texts[i]);
            send_expression();
        end

        // Random part: mostly well-formed expressions, with noise and broken ones.
        while (tokens_sent < TOKEN_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                if ($urandom_range(0, 9) == 0)
                    queue_wellformed($urandom_range(7, 15), 1'b1);
                else
                    queue_wellformed($urandom_range(0, 6), 1'b1);
            end
            else if (kind < 76) begin
                queue_text(special_texts[$urandom_range(0, 17)]);
            end
            else if (kind < 87) begin
                repeat ($urandom_range(1, 6))
                    expression_chars.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 98) begin
                // A well-formed expression with one character lost or corrupted.
                queue_wellformed($urandom_range(1, 5), 1'b0);
                cut = $urandom_range(0, expression_chars.size() - 1);
                if ($urandom_range(0, 1) == 0 && expression_chars.size() > 1)
                    expression_chars.delete(cut);
                else
                    expression_chars[cut] = 8'($urandom_range(0, 255));
            end
            else begin
                // Flood with digits around the stack depth to reach the full stack.
                repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4))
                    expression_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            send_expression();
        end
        token_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d expressions; %0d results checked, %0d mismatches.",
                 tokens_sent, expressions_sent, sb.results_checked, sb.mismatch_count);
        $display("Statuses seen: ok %0d, underflow %0d, div by zero %0d, overflow %0d, %s",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNDER], sb.status_seen[ST_DIVZERO],
                 sb.status_seen[ST_OVER],
                 $sformatf("empty %0d, zero to negative power %0d.",
                           sb.status_seen[ST_EMPTY], sb.status_seen[ST_ZNEGPOW]));
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3_200_000;
        $display("Run timed out with %0d results outstanding.", sb.pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/pee_pkg.sv
src/pee_token_if.sv
src/pee_result_if.sv
src/pee_iter.sv
src/pee_datapath.sv
src/pee_ctrl.sv
src/prefix_expression_evaluator_unit.sv
tb/testbench.sv
